@@ hw/rtl/stw_pkg.sv @@
// Shared types and register codes for the sliding time window counter.
package stw_pkg;

   localparam int INDEX_W  = 32;
   localparam int SPAN_W   = 31;
   localparam int COUNT_W  = 11;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PER_ITEM_MODE = 1'd1;

   typedef struct packed {
      logic signed [INDEX_W-1:0] index_value;
      logic [SPAN_W-1:0]         item_window;
      logic                      series_start;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] window_count;
      logic               not_available;
      logic               overflow;
      logic               order_error;
   } rsp_payload_type;

endpackage

@@ hw/rtl/stw_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module stw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/stw_search.sv @@
// Binary search over the circular index history for the first entry inside the window.
module stw_search #(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [$clog2(DEPTH)-1:0]   oldest,
   input  logic [$clog2(DEPTH+1)-1:0] span,
   input  logic signed [33:0]         low,
   input  logic [31:0]                rd_data,
   input  logic                       take,
   output logic                       rd_en,
   output logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic                       done,
   output logic [$clog2(DEPTH+1)-1:0] result
);
   import stw_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0] DEPTH_A = (AW + 1)'(DEPTH);

   logic          active_ff, active_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic signed [33:0] low_ff, low_in;

   logic          in_window;
   logic          more;
   logic [CW:0]   mid_sum;
   logic [AW:0]   addr_sum;

   // Entries are nondecreasing from oldest to newest, so the entries below the
   // window form a prefix; the search finds its length.
   assign in_window = $signed({{2{rd_data[INDEX_W-1]}}, rd_data}) >= low_ff;

   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      active_in = active_ff;
      oldest_in = oldest_ff;
      low_in    = low_ff;
      if (pend_ff) begin
         if (in_window) begin
            hi_in = mid_ff;
         end else begin
            lo_in = mid_ff + CW'(1);
         end
      end
      more     = lo_in < hi_in;
      mid_sum  = {1'b0, lo_in} + {1'b0, hi_in};
      mid_in   = mid_sum[CW:1];
      addr_sum = {1'b0, oldest_ff} + (AW + 1)'(mid_in);
      if (addr_sum >= DEPTH_A) begin
         addr_sum = addr_sum - DEPTH_A;
      end
      pend_in = active_ff && more;
      if (start) begin
         active_in = 1'b1;
         pend_in   = 1'b0;
         lo_in     = '0;
         hi_in     = span;
         oldest_in = oldest;
         low_in    = low;
      end else if (take) begin
         active_in = 1'b0;
      end
   end

   assign rd_en   = active_ff && more;
   assign rd_addr = addr_sum[AW-1:0];
   assign done    = active_ff && !more;
   assign result  = lo_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         pend_ff   <= pend_in;
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      oldest_ff <= oldest_in;
      low_ff    <= low_in;
   end

endmodule

@@ hw/rtl/sliding_time_window_count.sv @@
// Sliding time window counter top level: history bookkeeping, control and result register.
//
// Each request transfer carries a time index, a per-item window span and a
// series start flag; each one yields exactly one response transfer with the
// count of stored indices inside the window ending at that index, plus the
// not-available, overflow and order error flags.
// The csr port writes window_length and per_item_mode; write only while idle.
// The index is written to the history RAM at the request transfer, then a
// binary search reads the RAM once per cycle, the RAM read port setting the
// pace. With n stored entries the search makes at most m = ceil(log2(n + 1))
// RAM reads; an item with an order error makes none. The next request is
// taken only after the result has moved to the output register.
// The response sits in an output register; the next request is taken while
// it waits, and the block stalls only when a new result is ready and the
// previous one has not been taken.
// Synchronous reset empties the history (no clearing pass is needed), drops
// any pending response and sets window_length to 1 and per_item_mode to 0.
module sliding_time_window_count #(
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  stw_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output stw_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_we,
   input  logic [stw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stw_pkg::SPAN_W-1:0]       csr_wdata
);
   import stw_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int OW = CW + 1;
   localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

   typedef enum logic {ST_IDLE, ST_BUSY} state_type;

   state_type       state_ff, state_in;
   logic [AW-1:0]   wp_ff, wp_in;
   logic [CW-1:0]   stored_ff, stored_in;
   logic            trunc_ff, trunc_in;
   logic signed [INDEX_W-1:0] last_ff, last_in;
   logic [SPAN_W-1:0] win_len_ff, win_len_in;
   logic            per_item_ff, per_item_in;
   logic            err_ff, err_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic            accept;
   logic            err;
   logic [AW-1:0]   wp_base;
   logic [CW-1:0]   stored_base;
   logic [OW-1:0]   oldest_w;
   logic [SPAN_W-1:0] span_w;
   logic signed [33:0] low;

   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [INDEX_W-1:0] rd_data;
   logic            done;
   logic            take;
   logic [CW-1:0]   result;
   logic [CW-1:0]   count_v;
   logic [EW-1:0]   count_ext;

   assign accept = req_valid && !req_stall;
   assign take   = done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      wp_base     = req_payload.series_start ? '0 : wp_ff;
      stored_base = req_payload.series_start ? '0 : stored_ff;
      err = (stored_base != '0) && (req_payload.index_value < last_ff);
      span_w = per_item_ff ? req_payload.item_window : win_len_ff;
      low = $signed({{2{req_payload.index_value[INDEX_W-1]}}, req_payload.index_value})
            - $signed({3'b000, span_w}) + 34'sd1;

      state_in    = state_ff;
      wp_in       = wp_ff;
      stored_in   = stored_ff;
      trunc_in    = trunc_ff;
      last_in     = last_ff;
      win_len_in  = win_len_ff;
      per_item_in = per_item_ff;
      err_in      = err_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: win_len_in  = csr_wdata;
            CSR_PER_ITEM_MODE: per_item_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (accept) begin
         state_in = ST_BUSY;
         err_in   = err;
         if (req_payload.series_start) begin
            wp_in     = '0;
            stored_in = '0;
            trunc_in  = 1'b0;
         end
         if (!err) begin
            wp_in   = (wp_base == LAST_POS) ? '0 : wp_base + AW'(1);
            last_in = req_payload.index_value;
            if (stored_base >= DEPTH_C) begin
               stored_in = stored_base;
               trunc_in  = 1'b1;
            end else begin
               stored_in = stored_base + CW'(1);
            end
         end
      end else if (take) begin
         state_in = ST_IDLE;
      end

      // Oldest kept entry of the history after this item is stored.
      if (OW'(wp_in) >= OW'(stored_in)) begin
         oldest_w = OW'(wp_in) - OW'(stored_in);
      end else begin
         oldest_w = OW'(wp_in) + DEPTH_O - OW'(stored_in);
      end

      // Result: entries below the window form a prefix of length result.
      count_v   = stored_ff - result;
      rsp_in    = '0;
      if (err_ff) begin
         rsp_in.order_error = 1'b1;
      end else if (result == '0) begin
         if (trunc_ff) begin
            count_ext        = EW'(DEPTH_C);
            rsp_in.overflow  = 1'b1;
         end else begin
            count_ext            = '0;
            rsp_in.not_available = 1'b1;
         end
         rsp_in.window_count = count_ext[COUNT_W-1:0];
      end else begin
         count_ext = EW'(count_v);
         rsp_in.window_count = count_ext[COUNT_W-1:0];
      end
      if (err_ff) begin
         count_ext = '0;
      end

      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         stored_ff    <= '0;
         trunc_ff     <= 1'b0;
         win_len_ff   <= SPAN_W'(1);
         per_item_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         stored_ff    <= stored_in;
         trunc_ff     <= trunc_in;
         win_len_ff   <= win_len_in;
         per_item_ff  <= per_item_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      err_ff  <= err_in;
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   stw_ram #(
      .WIDTH(INDEX_W),
      .DEPTH(DEPTH)
   ) u_history (
      .clock  (clock),
      .wr_en  (accept && !err),
      .wr_addr(wp_base),
      .wr_data(req_payload.index_value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // An item with an order error searches an empty range and finishes at once.
   stw_search #(
      .DEPTH(DEPTH)
   ) u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .oldest (oldest_w[AW-1:0]),
      .span   (err ? '0 : stored_in),
      .low    (low),
      .rd_data(rd_data),
      .take   (take),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .done   (done),
      .result (result)
   );

endmodule

@@ hw/rtl/stw_checker.sv @@
// Port-level checks for the sliding time window counter, bound to the top level.
module stw_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input stw_pkg::rsp_payload_type rsp_payload,
   input logic                     rsp_valid,
   input logic                     rsp_stall
);
   import stw_pkg::*;

   // A response held by the receiver stays and does not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Each transfer occupies the block, so a second one cannot follow at once.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on back-to-back cycles");

   // An order error carries no count and no other flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.order_error |->
         rsp_payload.window_count == '0 && !rsp_payload.not_available &&
         !rsp_payload.overflow)
      else $error("order error with count or flags");

   // Not available means a zero count and no overflow.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.not_available |->
         rsp_payload.window_count == '0 && !rsp_payload.overflow)
      else $error("not available with count or overflow");

   // Reset drops any pending response.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sliding_time_window_count stw_checker u_checker (.*);
